/* hw/rtl/lrd_pkg.sv */
// Shared types and constants for the DDA line rasterizer.
package lrd_pkg;

  localparam int CoordW  = 6;
  localparam int RowW    = 7;
  localparam int IndexW  = 12;
  localparam int GlyphW  = 8;
  localparam int ColourW = 16;

  // Register reset value for cells per row.
  localparam logic [RowW-1:0] RowWidthReset = 7'd64;

  typedef logic [CoordW-1:0]  coord_t;
  typedef logic [RowW-1:0]    row_t;
  typedef logic [IndexW-1:0]  index_t;
  typedef logic [GlyphW-1:0]  glyph_t;
  typedef logic [ColourW-1:0] colour_t;

  // Signed minor delta needs one bit more than a coordinate.
  typedef logic signed [CoordW:0] delta_t;

  // Line geometry after clamping, axis choice and endpoint swap.
  typedef struct packed {
    logic   x_major;
    coord_t a0;
    coord_t a1;
    coord_t b0;
    coord_t d;
    delta_t dm;
  } setup_t;

  // One update of the minor coordinate and its error term.
  typedef struct packed {
    coord_t minor;
    coord_t err;
  } step_t;

endpackage

/* hw/rtl/lrd_if.sv */
// Handshake channel interfaces for line commands, cell writes and configuration.
interface lrd_cmd_if import lrd_pkg::*; ();
  logic    valid;
  logic    ready;
  coord_t  start_x;
  coord_t  start_y;
  coord_t  end_x;
  coord_t  end_y;
  glyph_t  glyph;
  colour_t colour;

  modport source(output valid, start_x, start_y, end_x, end_y, glyph, colour,
                 input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, glyph, colour,
               output ready);
endinterface

interface lrd_cell_if import lrd_pkg::*; ();
  logic    valid;
  logic    ready;
  coord_t  cell_x;
  coord_t  cell_y;
  index_t  cell_index;
  glyph_t  cell_glyph;
  colour_t cell_colour;
  logic    last_cell;

  modport source(output valid, cell_x, cell_y, cell_index, cell_glyph, cell_colour,
                 last_cell, input ready);
  modport sink(input valid, cell_x, cell_y, cell_index, cell_glyph, cell_colour,
               last_cell, output ready);
endinterface

interface lrd_cfg_if import lrd_pkg::*; ();
  logic valid;
  logic ready;
  row_t row_width;

  modport source(output valid, row_width, input ready);
  modport sink(input valid, row_width, output ready);
endinterface

/* hw/rtl/line_rasterizer_dda.sv */
// Top level of the DDA line rasterizer: sequencer, command registers and configuration.
//
// Usage: a line command (two endpoints, glyph, colour) arrives as a request on
// in_cmd. The block then emits one cell-write request on out_cell for every
// step along the major axis, the last one flagged by last_cell. The minor
// coordinate follows an exact integer error term, so no rounding drifts.
// in_cmd.ready is high only while the block is idle; a command of major
// length D occupies the block from acceptance through the setup state, which
// settles the geometry, and the run state, which streams D + 1 cells.
// The first cell leaves through the output register after the setup state.
// The pace is set by the single error accumulator, which advances one major
// step per cycle unless out_cell stalls.
// If the receiver drops out_cell.ready, the current cell holds in the output
// register and the sequencer waits; nothing is lost or repeated.
// cfg_wr sets row_width (always ready); write it only while the block is idle.
// Reset (rst_n low, synchronous) returns to idle, discards any line in
// progress and sets row_width to 64.
module line_rasterizer_dda import lrd_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input logic clk,
  input logic rst_n,
  lrd_cmd_if.sink    in_cmd,
  lrd_cell_if.source out_cell,
  lrd_cfg_if.sink    cfg_wr
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0] state_r, state_nxt;
  row_t       row_width_r;

  // Command registers, held for the whole line.
  coord_t  sx_r, sy_r, ex_r, ey_r;
  glyph_t  glyph_r;
  colour_t colour_r;

  // Walk state.
  logic   x_major_r;
  coord_t major_r, major_end_r, d_r;
  delta_t dm_r;
  step_t  cur_r;

  setup_t setup;
  step_t  step_nxt;
  logic   accept, free, load, last;
  coord_t cx, cy;

  assign in_cmd.ready = (state_r == ST_IDLE);
  assign accept       = in_cmd.valid && in_cmd.ready;
  assign cfg_wr.ready = 1'b1;

  lrd_setup #(.GRID_SIZE(GRID_SIZE)) u_setup (
    .start_x (sx_r),
    .start_y (sy_r),
    .end_x   (ex_r),
    .end_y   (ey_r),
    .setup   (setup)
  );

  lrd_step u_step (
    .cur (cur_r),
    .dm  (dm_r),
    .d   (d_r),
    .nxt (step_nxt)
  );

  assign last = (major_r == major_end_r);
  assign load = (state_r == ST_RUN) && free;
  assign cx   = x_major_r ? major_r : cur_r.minor;
  assign cy   = x_major_r ? cur_r.minor : major_r;

  lrd_cell_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .cx        (cx),
    .cy        (cy),
    .row_width (row_width_r),
    .glyph     (glyph_r),
    .colour    (colour_r),
    .last      (last),
    .free      (free),
    .out_cell  (out_cell)
  );

  // Sequencer: take a command, settle its geometry, then step once per free slot.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: state_nxt = ST_RUN;
      ST_RUN: begin
        if (load && last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_width_r <= RowWidthReset;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        row_width_r <= cfg_wr.row_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx_r     <= in_cmd.start_x;
      sy_r     <= in_cmd.start_y;
      ex_r     <= in_cmd.end_x;
      ey_r     <= in_cmd.end_y;
      glyph_r  <= in_cmd.glyph;
      colour_r <= in_cmd.colour;
    end
    if (state_r == ST_SETUP) begin
      x_major_r   <= setup.x_major;
      major_r     <= setup.a0;
      major_end_r <= setup.a1;
      d_r         <= setup.d;
      dm_r        <= setup.dm;
      cur_r.minor <= setup.b0;
      cur_r.err   <= '0;
    end else if (load) begin
      major_r <= major_r + 1'b1;
      cur_r   <= step_nxt;
    end
  end

endmodule

/* hw/rtl/lrd_setup.sv */
// Clamps endpoints, picks the major axis and orders the endpoints along it.
module lrd_setup import lrd_pkg::*; #(
  parameter int GRID_SIZE = 64
) (
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output setup_t setup
);

  localparam coord_t MaxCoord = CoordW'(GRID_SIZE - 1);

  coord_t sx, sy, ex, ey;
  coord_t adx, ady;
  coord_t a0, a1, b0, b1;

  always_comb begin
    sx = (start_x > MaxCoord) ? MaxCoord : start_x;
    sy = (start_y > MaxCoord) ? MaxCoord : start_y;
    ex = (end_x > MaxCoord) ? MaxCoord : end_x;
    ey = (end_y > MaxCoord) ? MaxCoord : end_y;
    adx = (ex >= sx) ? ex - sx : sx - ex;
    ady = (ey >= sy) ? ey - sy : sy - ey;

    setup.x_major = (adx > ady);
    if (setup.x_major) begin
      a0 = sx; a1 = ex; b0 = sy; b1 = ey;
    end else begin
      a0 = sy; a1 = ey; b0 = sx; b1 = ex;
    end
    // Walk from the lower major coordinate upward.
    if (a0 > a1) begin
      setup.a0 = a1; setup.a1 = a0; setup.b0 = b1;
      setup.dm = $signed({1'b0, b0}) - $signed({1'b0, b1});
    end else begin
      setup.a0 = a0; setup.a1 = a1; setup.b0 = b0;
      setup.dm = $signed({1'b0, b1}) - $signed({1'b0, b0});
    end
    setup.d = setup.a1 - setup.a0;
  end

endmodule

/* hw/rtl/lrd_step.sv */
// Error accumulator unit: adds the minor delta and corrects once against the major delta.
module lrd_step import lrd_pkg::*; (
  input  step_t cur,
  input  delta_t dm,
  input  coord_t d,
  output step_t nxt
);

  logic signed [CoordW+1:0] sum;
  logic signed [CoordW+1:0] d_s;

  // The remainder stays in [0, d) because |dm| never exceeds d.
  always_comb begin
    d_s = $signed({2'b00, d});
    sum = $signed({2'b00, cur.err}) + (CoordW+2)'(dm);
    nxt = cur;
    if (sum >= d_s) begin
      nxt.err   = CoordW'(sum - d_s);
      nxt.minor = cur.minor + 1'b1;
    end else if (sum < 0) begin
      nxt.err   = CoordW'(sum + d_s);
      nxt.minor = cur.minor - 1'b1;
    end else begin
      nxt.err = CoordW'(sum);
    end
  end

endmodule

/* hw/rtl/lrd_cell_out.sv */
// Output register for cell writes, forming the linear cell index on load.
module lrd_cell_out import lrd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  coord_t  cx,
  input  coord_t  cy,
  input  row_t    row_width,
  input  glyph_t  glyph,
  input  colour_t colour,
  input  logic    last,
  output logic    free,
  lrd_cell_if.source out_cell
);

  logic    valid_r;
  coord_t  x_r, y_r;
  index_t  index_r;
  glyph_t  glyph_r;
  colour_t colour_r;
  logic    last_r;
  logic [CoordW+RowW:0] index_full;

  assign index_full = (CoordW+RowW+1)'(cy * row_width) + (CoordW+RowW+1)'(cx);
  assign free = !valid_r || out_cell.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_cell.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r      <= cx;
      y_r      <= cy;
      index_r  <= index_full[IndexW-1:0];
      glyph_r  <= glyph;
      colour_r <= colour;
      last_r   <= last;
    end
  end

  assign out_cell.valid       = valid_r;
  assign out_cell.cell_x      = x_r;
  assign out_cell.cell_y      = y_r;
  assign out_cell.cell_index  = index_r;
  assign out_cell.cell_glyph  = glyph_r;
  assign out_cell.cell_colour = colour_r;
  assign out_cell.last_cell   = last_r;

endmodule
